// ----- rtl/sctg_pkg.sv -----
// Shared types and constants of the sprite column tile generator.
// Holds the work item and status structs, command codes and sizes.
// Depends on nothing; front, back and top use it by scoped names, and the bench imports it.
package sctg_pkg;

	localparam int STORE_BYTES     = 8192;
	localparam int SHAPE_BYTES     = 128;
	localparam int ROWS_PER_OBJECT = 32;

	// The store is split into even and odd byte halves so one word read gives both bytes.
	localparam int STORE_WORDS = STORE_BYTES / 2;
	localparam int WORD_AW     = $clog2(STORE_WORDS);
	localparam int SHAPE_AW    = $clog2(SHAPE_BYTES);
	localparam int SLOTS       = 2 * ROWS_PER_OBJECT;
	localparam int SLOT_W      = $clog2(SLOTS);

	localparam int X_W    = 13;
	localparam int Y_W    = 9;
	localparam int CODE_W = 14;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [7:0] HIGH_BLOCK      = 8'ha0;
	localparam int         ROW_SKIP_BIT    = 3;
	localparam int         SAME_COLUMN_BIT = 2;
	localparam int         NEG_X_BIT       = 6;
	localparam int         FLIP_BASE       = 248;
	localparam int         COLUMN_STEP     = 16;
	localparam int         TILE_STEP       = 8;
	localparam int         NEG_X_OFFSET    = 256;

	typedef enum logic [1:0] {
		CMD_STORE_WR = 2'd0,
		CMD_SHAPE_WR = 2'd1,
		CMD_FRAME    = 2'd2,
		CMD_OBJECT   = 2'd3
	} cmd_t;

	typedef enum logic {
		CFG_SCREEN_FLIP = 1'b0,
		CFG_VIDEO_ON    = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DRAIN
	} bk_state_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [12:0] addr;
		logic [7:0]  data;
		logic [7:0]  neg_y;
		logic [7:0]  group;
		logic [7:0]  x;
		logic [7:0]  attr;
	} item_t;

	typedef struct packed {
		logic idle;
		logic pipe_empty;
		logic pend_valid;
	} bk_status_t;

endpackage

// ----- rtl/sctg_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the attribute store halves and the shape table; no dependencies.
module sctg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/sctg_front.sv -----
// Front end: accepts input words, drops those that have no effect and queues the rest.
// Depends on sctg_pkg for the item struct and command codes.
module sctg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [12:0]        wr_addr,
	input  logic [7:0]         wr_byte,
	input  logic [7:0]         obj_neg_y,
	input  logic [7:0]         obj_group,
	input  logic [7:0]         obj_x,
	input  logic [7:0]         obj_attr,
	input  logic               video_on,
	input  logic               pop,
	output logic               q_valid,
	output sctg_pkg::item_t    q_item
);

	sctg_pkg::item_t              fifo_q [sctg_pkg::QUEUE_DEPTH];
	logic [sctg_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [sctg_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [sctg_pkg::QCNT_W-1:0]  count_q;
	sctg_pkg::item_t              item;
	logic                         keep;
	logic                         push;

	always_comb begin
		item.cmd   = sctg_pkg::cmd_t'(cmd);
		item.addr  = wr_addr;
		item.data  = wr_byte;
		item.neg_y = obj_neg_y;
		item.group = obj_group;
		item.x     = obj_x;
		item.attr  = obj_attr;
		case (item.cmd)
			sctg_pkg::CMD_SHAPE_WR: begin
				keep = (wr_addr < 13'(sctg_pkg::SHAPE_BYTES));
			end
			sctg_pkg::CMD_OBJECT: begin
				keep = video_on && ((obj_neg_y | obj_group | obj_x | obj_attr) != 8'd0);
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	assign in_stall = (count_q == sctg_pkg::QCNT_W'(sctg_pkg::QUEUE_DEPTH));
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (count_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

endmodule

// ----- rtl/sctg_back.sv -----
// Back end: executes queued words, walks the shape rows of an object and emits tiles.
// Depends on sctg_pkg and instantiates sctg_ram for the store halves and shape table.
module sctg_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  sctg_pkg::item_t                 q_item,
	output logic                            pop,
	input  logic                            screen_flip,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sctg_pkg::CODE_W-1:0]     tile_code,
	output logic [3:0]                      tile_color,
	output logic                            mirror_x,
	output logic                            mirror_y,
	output logic signed [sctg_pkg::X_W-1:0] pos_x,
	output logic signed [sctg_pkg::Y_W-1:0] pos_y,
	output logic                            last,
	output sctg_pkg::bk_status_t            status
);

	sctg_pkg::bk_state_t         state_q, state_d;
	logic [sctg_pkg::SLOT_W-1:0] slot_q;
	logic [7:0]                  neg_y_q, group_q, x_q, attr_q;
	logic [sctg_pkg::X_W-1:0]    col_x_q;

	logic                        adv, issue, flush;
	logic                        is_obj, is_store, is_shape, is_frame;

	logic                        v_s1_q;
	logic [sctg_pkg::SLOT_W-1:0] slot_s1;
	logic                        v_s2_q;
	logic [sctg_pkg::X_W-1:0]    x_s2;
	logic [7:0]                  y_s2;

	logic [7:0]                  shape_rd;
	logic [7:0]                  lo_rd, hi_rd;
	logic                        lo_we, hi_we;
	logic                        attr_re;
	logic [sctg_pkg::WORD_AW-1:0] attr_raddr;

	logic                        keep;
	logic [4:0]                  row;
	logic                        tile_t;
	logic                        high_block;
	logic [sctg_pkg::X_W-1:0]    start_x, cx, tile_x;
	logic [7:0]                  tile_y;

	logic [sctg_pkg::CODE_W-1:0]     new_code;
	logic [3:0]                      new_color;
	logic                            new_mx, new_my;
	logic [sctg_pkg::X_W-1:0]        new_px;
	logic [sctg_pkg::Y_W-1:0]        new_py;

	logic                            pend_v_q;
	logic [sctg_pkg::CODE_W-1:0]     pend_code_q;
	logic [3:0]                      pend_color_q;
	logic                            pend_mx_q, pend_my_q;
	logic [sctg_pkg::X_W-1:0]        pend_px_q;
	logic [sctg_pkg::Y_W-1:0]        pend_py_q;

	logic                            out_valid_q;
	logic [sctg_pkg::CODE_W-1:0]     out_code_q;
	logic [3:0]                      out_color_q;
	logic                            out_mx_q, out_my_q;
	logic [sctg_pkg::X_W-1:0]        out_px_q;
	logic [sctg_pkg::Y_W-1:0]        out_py_q;
	logic                            out_last_q;

	// The whole tile pipeline freezes while a finished tile waits at the output.
	assign adv = !out_valid_q || !out_stall;

	assign is_obj   = (q_item.cmd == sctg_pkg::CMD_OBJECT);
	assign is_store = (q_item.cmd == sctg_pkg::CMD_STORE_WR);
	assign is_shape = (q_item.cmd == sctg_pkg::CMD_SHAPE_WR);
	assign is_frame = (q_item.cmd == sctg_pkg::CMD_FRAME);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		issue   = 1'b0;
		flush   = 1'b0;
		case (state_q)
			sctg_pkg::BK_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (is_obj) begin
						state_d = sctg_pkg::BK_RUN;
					end
				end
			end
			sctg_pkg::BK_RUN: begin
				if (adv) begin
					issue = 1'b1;
					if (slot_q == sctg_pkg::SLOT_W'(sctg_pkg::SLOTS - 1)) begin
						state_d = sctg_pkg::BK_DRAIN;
					end
				end
			end
			sctg_pkg::BK_DRAIN: begin
				if (adv && !v_s1_q && !v_s2_q) begin
					flush   = 1'b1;
					state_d = sctg_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = sctg_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sctg_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Memories: the store is written as bytes into its even or odd half.
	assign lo_we = pop && is_store && !q_item.addr[0];
	assign hi_we = pop && is_store && q_item.addr[0];

	sctg_ram #(.WIDTH(8), .DEPTH(sctg_pkg::STORE_WORDS)) u_store_lo (
		.clk   (clk),
		.we    (lo_we),
		.waddr (q_item.addr[sctg_pkg::WORD_AW:1]),
		.wdata (q_item.data),
		.re    (attr_re),
		.raddr (attr_raddr),
		.rdata (lo_rd)
	);

	sctg_ram #(.WIDTH(8), .DEPTH(sctg_pkg::STORE_WORDS)) u_store_hi (
		.clk   (clk),
		.we    (hi_we),
		.waddr (q_item.addr[sctg_pkg::WORD_AW:1]),
		.wdata (q_item.data),
		.re    (attr_re),
		.raddr (attr_raddr),
		.rdata (hi_rd)
	);

	sctg_ram #(.WIDTH(8), .DEPTH(sctg_pkg::SHAPE_BYTES)) u_shape (
		.clk   (clk),
		.we    (pop && is_shape),
		.waddr (q_item.addr[sctg_pkg::SHAPE_AW-1:0]),
		.wdata (q_item.data),
		.re    (issue),
		.raddr ({group_q[7:5], slot_q[sctg_pkg::SLOT_W-1:2]}),
		.rdata (shape_rd)
	);

	// Row stage: the shape byte decides skip and column restart for this slot.
	always_comb begin
		row        = slot_s1[sctg_pkg::SLOT_W-1:1];
		tile_t     = slot_s1[0];
		keep       = !shape_rd[sctg_pkg::ROW_SKIP_BIT];
		high_block = ((group_q & sctg_pkg::HIGH_BLOCK) == sctg_pkg::HIGH_BLOCK);
		start_x    = {5'd0, x_q} -
			(attr_q[sctg_pkg::NEG_X_BIT] ? sctg_pkg::X_W'(sctg_pkg::NEG_X_OFFSET) : '0);
		cx         = (keep && !shape_rd[sctg_pkg::SAME_COLUMN_BIT]) ? start_x : col_x_q;
		tile_x     = cx + (tile_t ? sctg_pkg::X_W'(sctg_pkg::TILE_STEP) : '0);
		tile_y     = {row, 3'd0} - neg_y_q;
		attr_raddr = {high_block, group_q[4:0], tile_t, shape_rd[1:0], row[2:0]};
		attr_re    = adv && v_s1_q && keep;
	end

	// Tile stage: store bytes become the tile word, with screen flip applied.
	always_comb begin
		new_code  = {attr_q[3:0], hi_rd[1:0], lo_rd};
		new_color = hi_rd[5:2];
		new_mx    = hi_rd[6] ^ screen_flip;
		new_my    = hi_rd[7] ^ screen_flip;
		new_px    = screen_flip ? (sctg_pkg::X_W'(sctg_pkg::FLIP_BASE) - x_s2) : x_s2;
		new_py    = screen_flip ? (sctg_pkg::Y_W'(sctg_pkg::FLIP_BASE) - {1'b0, y_s2})
		                        : {1'b0, y_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			col_x_q     <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && is_obj) begin
				slot_q <= '0;
			end else if (issue) begin
				slot_q <= slot_q + 1'b1;
			end
			if (pop && is_frame) begin
				col_x_q <= '0;
			end else if (adv && v_s1_q) begin
				if (slot_s1 == sctg_pkg::SLOT_W'(sctg_pkg::SLOTS - 1)) begin
					col_x_q <= cx + sctg_pkg::X_W'(sctg_pkg::COLUMN_STEP);
				end else begin
					col_x_q <= cx;
				end
			end
			if (adv) begin
				v_s1_q      <= issue;
				v_s2_q      <= v_s1_q && keep;
				out_valid_q <= pend_v_q && (v_s2_q || flush);
				if (v_s2_q) begin
					pend_v_q <= 1'b1;
				end else if (flush) begin
					pend_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_obj) begin
			neg_y_q <= q_item.neg_y;
			group_q <= q_item.group;
			x_q     <= q_item.x;
			attr_q  <= q_item.attr;
		end
		if (adv) begin
			slot_s1 <= slot_q;
			x_s2    <= tile_x;
			y_s2    <= tile_y;
			if (v_s2_q) begin
				pend_code_q  <= new_code;
				pend_color_q <= new_color;
				pend_mx_q    <= new_mx;
				pend_my_q    <= new_my;
				pend_px_q    <= new_px;
				pend_py_q    <= new_py;
			end
			if (v_s2_q || flush) begin
				out_code_q  <= pend_code_q;
				out_color_q <= pend_color_q;
				out_mx_q    <= pend_mx_q;
				out_my_q    <= pend_my_q;
				out_px_q    <= pend_px_q;
				out_py_q    <= pend_py_q;
				out_last_q  <= flush;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign tile_code  = out_code_q;
	assign tile_color = out_color_q;
	assign mirror_x   = out_mx_q;
	assign mirror_y   = out_my_q;
	assign pos_x      = out_px_q;
	assign pos_y      = out_py_q;
	assign last       = out_last_q;

	assign status.idle       = (state_q == sctg_pkg::BK_IDLE);
	assign status.pipe_empty = !v_s1_q && !v_s2_q;
	assign status.pend_valid = pend_v_q;

endmodule

// ----- rtl/sprite_column_tile_generator.sv -----
// Sprite column tile generator: turns object entries into 8x8 tile draw words.
// Store, shape and frame words are handled one at a time by the back end; an object
// entry walks 64 slots there, two tiles per shape row, and then drains its pipeline.
// Reset clears control state, column x and screen flip and sets video on; the attribute
// store and shape table keep no reset and need no clearing pass.
module sprite_column_tile_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic                            cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic [12:0]                     wr_addr,
	input  logic [7:0]                      wr_byte,
	input  logic [7:0]                      obj_neg_y,
	input  logic [7:0]                      obj_group,
	input  logic [7:0]                      obj_x,
	input  logic [7:0]                      obj_attr,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [13:0]                     tile_code,
	output logic [3:0]                      tile_color,
	output logic                            mirror_x,
	output logic                            mirror_y,
	output logic signed [12:0]              pos_x,
	output logic signed [8:0]               pos_y,
	output logic                            last
);

	logic                 screen_flip_q;
	logic                 video_on_q;
	logic                 q_valid;
	logic                 bk_pop;
	sctg_pkg::item_t      q_item;
	sctg_pkg::bk_status_t bk_status;

	// Config registers: the user changes them only while idle (the block does not enforce
	// it), so the front end's drop decision and the back end's flip logic read them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_flip_q <= 1'b0;
			video_on_q    <= 1'b1;
		end else if (cfg_we) begin
			case (sctg_pkg::cfg_idx_t'(cfg_index))
				sctg_pkg::CFG_SCREEN_FLIP: screen_flip_q <= cfg_data;
				sctg_pkg::CFG_VIDEO_ON:    video_on_q    <= cfg_data;
				default:                   video_on_q    <= video_on_q;
			endcase
		end
	end

	// The front end takes every word it has room for. Object entries that are all
	// zero or arrive with video off, and shape writes beyond the table, are dropped
	// there; the rest wait in a two-entry queue.
	sctg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.wr_byte   (wr_byte),
		.obj_neg_y (obj_neg_y),
		.obj_group (obj_group),
		.obj_x     (obj_x),
		.obj_attr  (obj_attr),
		.video_on  (video_on_q),
		.pop       (bk_pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// The back end runs one queued word at a time. For an object it issues one slot
	// per cycle unless the output stalls, via a shape read, a store read and a tile
	// stage. One tile is held back so the entry's final tile can carry the last mark.
	sctg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.pop         (bk_pop),
		.screen_flip (screen_flip_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tile_code   (tile_code),
		.tile_color  (tile_color),
		.mirror_x    (mirror_x),
		.mirror_y    (mirror_y),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.last        (last),
		.status      (bk_status)
	);

	// The back end never takes a word from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) bk_pop |-> q_valid)
		else $error("back end popped an empty queue");

	// An idle back end takes any waiting word at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(bk_status.idle && q_valid) |-> bk_pop)
		else $error("idle back end left a queued word waiting");

	// When the back end is idle its pipeline and held tile are empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.idle |-> (bk_status.pipe_empty && !bk_status.pend_valid))
		else $error("back end idle with tiles still in flight");

endmodule

// ----- bench/tb_sprite_column_tile_generator.sv -----
// Self-checking bench for the sprite column tile generator: store, shape, frame and
// object words go in, and every tile draw word that comes out is checked against an
// in-line prediction. Depends on rtl/sctg_pkg.sv and rtl/sprite_column_tile_generator.sv.
module tb_sprite_column_tile_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import sctg_pkg::*;

	// The whole run must end well inside this many cycles, or it counts as hung.
	localparam int CYCLE_LIMIT   = 500000;
	// Up to two entries can wait in front of the back end. An entry whose rows are all
	// skipped produces no tile, so after the last tile arrives we still give the block
	// this long to go idle.
	localparam int SETTLE_CYCLES = 250;
	localparam int WORDS_PER_MODE = 54;
	localparam int LONG_HOLD     = 400;

	// One expected tile draw word, in the block's own widths.
	typedef struct packed {
		logic [13:0]        code;
		logic [3:0]         color;
		logic               mx;
		logic               my;
		logic signed [12:0] x;
		logic signed [8:0]  y;
		logic               last;
	} tile_t;

	// One row of the directed table. line_fill >= 0 overwrites all 16 shape bytes
	// of the entry's line with that value first; want >= 0 is the tile count that
	// the entry must give, read straight off the behavior.
	typedef struct {
		cmd_t op;
		int   addr;
		int   data;
		int   neg_y;
		int   grp;
		int   x;
		int   attr;
		int   line_fill;
		bit   flip;
		bit   video;
		int   want;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic        cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [12:0] wr_addr;
	logic [7:0]  wr_byte;
	logic [7:0]  obj_neg_y;
	logic [7:0]  obj_group;
	logic [7:0]  obj_x;
	logic [7:0]  obj_attr;
	logic        out_valid;
	logic        out_stall;
	logic [13:0] tile_code;
	logic [3:0]  tile_color;
	logic        mirror_x;
	logic        mirror_y;
	logic signed [12:0] pos_x;
	logic signed [8:0]  pos_y;
	logic        last;

	// Prediction state: our own copy of the store, the shape table, the running
	// column x and both registers, updated as words are accepted.
	logic [7:0]  attr_mirror [STORE_BYTES];
	logic [7:0]  shape_mirror [SHAPE_BYTES];
	logic [12:0] col_x = '0;
	bit          flip_on = 1'b0;
	bit          video_en = 1'b1;
	tile_t       pending_tiles [$];
	int          last_tile_count = 0;

	// Stimulus-side bookkeeping: which bytes have been written so far, and the shape
	// bytes as the stimulus wrote them, so that no entry ever reads a byte that was
	// never written.
	bit          attr_set [STORE_BYTES];
	bit          shape_set [SHAPE_BYTES];
	logic [7:0]  gen_shape [SHAPE_BYTES];
	bit          gen_flip = 1'b0;
	bit          gen_video = 1'b1;

	int          snd_idle = 33;
	int          rcv_idle = 51;
	int          hold_left = 0;
	int          fault_count = 0;
	int          cycle_count = 0;

	// Blocks that most object entries draw from, so the store fills up quickly.
	// The first and last blocks put every block bit at both values.
	logic [4:0]  block_pool [4] = '{5'd0, 5'd31, 5'd10, 5'd21};

	step_t steps [23] = '{
		// Store writes at both ends of the address space and with extreme bytes.
		'{CMD_STORE_WR, 0,      'hFF, 0,    0,    0,    0,    -1,   0, 1, -1},
		'{CMD_STORE_WR, 8191,   'hC3, 0,    0,    0,    0,    -1,   0, 1, -1},
		'{CMD_STORE_WR, 'h1FFE, 'hFF, 0,    0,    0,    0,    -1,   0, 1, -1},
		// Shape writes at both ends of the table, then two out of range.
		'{CMD_SHAPE_WR, 0,      'h00, 0,    0,    0,    0,    -1,   0, 1, -1},
		'{CMD_SHAPE_WR, 127,    'hFF, 0,    0,    0,    0,    -1,   0, 1, -1},
		'{CMD_SHAPE_WR, 128,    'h00, 0,    0,    0,    0,    -1,   0, 1, -1},
		'{CMD_SHAPE_WR, 8191,   'h55, 0,    0,    0,    0,    -1,   0, 1, -1},
		// Frame start with every unused field at ones.
		'{CMD_FRAME,    8191,   'hFF, 'hFF, 'hFF, 'hFF, 'hFF, -1,   0, 1, -1},
		// An all-zero entry draws nothing, whatever the write fields hold.
		'{CMD_OBJECT,   8191,   'hFF, 0,    0,    0,    0,    -1,   0, 1, 0},
		'{CMD_OBJECT,   0,      0,    0,    0,    0,    'h01, -1,   0, 1, -1},
		// All ones: last shape line, last high block, x minus 256, top bank.
		'{CMD_OBJECT,   0,      0,    'hFF, 'hFF, 'hFF, 'hFF, -1,   0, 1, -1},
		// Every row skipped: no tiles, but column x still moves on by 16.
		'{CMD_OBJECT,   0,      0,    'h10, 'hE5, 'h30, 'h00, 'h08, 0, 1, 0},
		// Every row keeps the column x left over from the entry before.
		'{CMD_OBJECT,   0,      0,    'h20, 'h20, 'h40, 'h05, 'h04, 0, 1, -1},
		// Column x goes negative and the vertical start wraps.
		'{CMD_OBJECT,   0,      0,    'h01, 'h40, 'hFF, 'h40, 'h00, 0, 1, -1},
		'{CMD_FRAME,    0,      0,    0,    0,    0,    0,    -1,   0, 1, -1},
		'{CMD_OBJECT,   0,      0,    'h00, 'h60, 'h08, 'h02, 'h07, 0, 1, -1},
		// High block bit set by the group pattern, then a store rewrite under it.
		'{CMD_OBJECT,   0,      0,    'h80, 'hA0, 'h7F, 'h0F, -1,   0, 1, -1},
		'{CMD_STORE_WR, 'h1000, 'h5A, 0,    0,    0,    0,    -1,   0, 1, -1},
		'{CMD_OBJECT,   0,      0,    'h80, 'hA0, 'h7F, 'h0F, -1,   0, 1, -1},
		// Video off: entries draw nothing.
		'{CMD_OBJECT,   0,      0,    'h33, 'hFF, 'hC8, 'h8F, -1,   0, 0, 0},
		'{CMD_OBJECT,   0,      0,    0,    0,    0,    'h01, -1,   0, 0, 0},
		// Screen flip on: positions mirror about 248 and both flips invert.
		'{CMD_OBJECT,   0,      0,    'hFF, 'hFF, 'hFF, 'hFF, -1,   1, 1, -1},
		'{CMD_OBJECT,   0,      0,    'h01, 'h40, 'h00, 'h40, -1,   1, 1, -1}
	};

	sprite_column_tile_generator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.wr_byte    (wr_byte),
		.obj_neg_y  (obj_neg_y),
		.obj_group  (obj_group),
		.obj_x      (obj_x),
		.obj_attr   (obj_attr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tile_code  (tile_code),
		.tile_color (tile_color),
		.mirror_x   (mirror_x),
		.mirror_y   (mirror_y),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one accepted word to the prediction state and appends the tiles that
	// it draws, in row order with the left tile first.
	task automatic predict_tiles(input item_t w, output int made);
		tile_t       tl;
		logic [6:0]  line;
		logic [12:0] base;
		logic [12:0] a;
		logic [12:0] tx;
		logic [7:0]  sh;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [7:0]  ty;
		logic [8:0]  fy;
		int          row;
		int          t;
		made = 0;
		case (w.cmd)
			CMD_STORE_WR: attr_mirror[w.addr] = w.data;
			CMD_SHAPE_WR: begin
				if (w.addr < SHAPE_BYTES)
					shape_mirror[w.addr[6:0]] = w.data;
			end
			CMD_FRAME: col_x = '0;
			CMD_OBJECT: begin
				if ({w.neg_y, w.group, w.x, w.attr} != 32'd0 && video_en) begin
					line = {w.group[7:5], 4'd0};
					base = {(w.group & HIGH_BLOCK) == HIGH_BLOCK, w.group[4:0], 7'd0};
					for (row = 0; row < ROWS_PER_OBJECT; row++) begin
						// Two rows share each shape byte of the 16-byte line.
						sh = shape_mirror[7'(line + row / 2)];
						if (sh[ROW_SKIP_BIT])
							continue;
						if (!sh[SAME_COLUMN_BIT]) begin
							col_x = {5'd0, w.x};
							if (w.attr[NEG_X_BIT])
								col_x = col_x - 13'(NEG_X_OFFSET);
						end
						for (t = 0; t < 2; t++) begin
							a = base + 13'(t * 64 + (row % 8) * 2 + sh[1:0] * 16);
							lo = attr_mirror[a];
							hi = attr_mirror[a + 13'd1];
							tx = col_x + 13'(t * TILE_STEP);
							ty = 8'(row * 8) - w.neg_y;
							fy = {1'b0, ty};
							tl.mx = hi[6];
							tl.my = hi[7];
							if (flip_on) begin
								tx = 13'(FLIP_BASE) - tx;
								fy = 9'(FLIP_BASE) - fy;
								tl.mx = ~tl.mx;
								tl.my = ~tl.my;
							end
							tl.code = {w.attr[3:0], hi[1:0], lo};
							tl.color = hi[5:2];
							tl.x = tx;
							tl.y = fy;
							tl.last = 1'b0;
							pending_tiles.push_back(tl);
							made++;
						end
					end
					if (made > 0) begin
						tl = pending_tiles.pop_back();
						tl.last = 1'b1;
						pending_tiles.push_back(tl);
					end
					col_x = col_x + 13'(COLUMN_STEP);
				end
			end
		endcase
	endtask

	task automatic note_fault(input string msg);
		if (fault_count < 10)
			$display("%s", msg);
		fault_count++;
	endtask

	// Register writes and accepted words both land at the rising edge, the same
	// edge at which the block itself takes them.
	always @(posedge clk) begin : accept_words
		item_t w;
		if (arst_n && cfg_we) begin
			if (cfg_idx_t'(cfg_index) == CFG_SCREEN_FLIP)
				flip_on = cfg_data;
			else
				video_en = cfg_data;
		end
		if (arst_n && in_valid && !in_stall) begin
			w.cmd = cmd_t'(cmd);
			w.addr = wr_addr;
			w.data = wr_byte;
			w.neg_y = obj_neg_y;
			w.group = obj_group;
			w.x = obj_x;
			w.attr = obj_attr;
			predict_tiles(w, last_tile_count);
		end
	end

	// Every accepted tile must match the oldest one still expected.
	always @(posedge clk) begin : check_tiles
		tile_t got;
		tile_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.code = tile_code;
			got.color = tile_color;
			got.mx = mirror_x;
			got.my = mirror_y;
			got.x = pos_x;
			got.y = pos_y;
			got.last = last;
			if (pending_tiles.size() == 0) begin
				note_fault($sformatf("cycle %0d: tile code=%h x=%0d y=%0d with none expected",
					cycle_count, got.code, got.x, got.y));
			end else begin
				want = pending_tiles.pop_front();
				if (got !== want)
					note_fault($sformatf({"cycle %0d: tile mismatch, expected code=%h color=%h ",
						"mx=%b my=%b x=%0d y=%0d last=%b, got code=%h color=%h mx=%b my=%b ",
						"x=%0d y=%0d last=%b"}, cycle_count,
						want.code, want.color, want.mx, want.my, want.x, want.y, want.last,
						got.code, got.color, got.mx, got.my, got.x, got.y, got.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sprite_column_tile_generator regression: fail");
			$finish;
		end
	end

	// Receiver side. A long hold, once requested, is counted out here so that the
	// sender can keep offering words meanwhile; otherwise the stall is random.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle);
			end
		end
	end

	// Offers one word from a falling edge, with random idle cycles first, and holds
	// it until the block takes it. Returns at the falling edge after acceptance.
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= w.cmd;
		wr_addr <= w.addr;
		wr_byte <= w.data;
		obj_neg_y <= w.neg_y;
		obj_group <= w.group;
		obj_x <= w.x;
		obj_attr <= w.attr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (w.cmd == CMD_STORE_WR)
			attr_set[w.addr] = 1'b1;
		if (w.cmd == CMD_SHAPE_WR && w.addr < SHAPE_BYTES) begin
			gen_shape[w.addr[6:0]] = w.data;
			shape_set[w.addr[6:0]] = 1'b1;
		end
	endtask

	// Shape bytes skip their row in 30 percent of cases; the other bits are free.
	function automatic logic [7:0] shape_byte();
		logic [7:0] b;
		b = 8'($urandom);
		b[ROW_SKIP_BIT] = ($urandom_range(99) < 30);
		return b;
	endfunction

	// Writes, ahead of an object entry, every shape and store byte that the entry
	// will read and that has not been written yet.
	task automatic prime_reads(input item_t w, input int line_fill);
		item_t       fill;
		logic [6:0]  line;
		logic [12:0] base;
		logic [12:0] a;
		logic [7:0]  sh;
		int          row;
		int          t;
		int          k;
		if ({w.neg_y, w.group, w.x, w.attr} == 32'd0 || !gen_video)
			return;
		line = {w.group[7:5], 4'd0};
		fill = '0;
		fill.cmd = CMD_SHAPE_WR;
		for (row = 0; row < 16; row++) begin
			if (line_fill >= 0 || !shape_set[line + row]) begin
				fill.addr = 13'(line + row);
				fill.data = (line_fill >= 0) ? 8'(line_fill) : shape_byte();
				send_word(fill);
			end
		end
		fill.cmd = CMD_STORE_WR;
		base = {(w.group & HIGH_BLOCK) == HIGH_BLOCK, w.group[4:0], 7'd0};
		for (row = 0; row < ROWS_PER_OBJECT; row++) begin
			sh = gen_shape[7'(line + row / 2)];
			if (!sh[ROW_SKIP_BIT]) begin
				for (t = 0; t < 2; t++) begin
					for (k = 0; k < 2; k++) begin
						a = base + 13'(t * 64 + (row % 8) * 2 + sh[1:0] * 16 + k);
						if (!attr_set[a]) begin
							fill.addr = a;
							fill.data = 8'($urandom);
							send_word(fill);
						end
					end
				end
			end
		end
	endtask

	// Mostly well-formed object entries; the rest are writes, frame starts and
	// empty entries. Unused fields always carry random junk.
	task automatic random_word(output item_t w);
		int pick;
		w.addr = 13'($urandom);
		w.data = 8'($urandom);
		w.neg_y = 8'($urandom);
		w.group = 8'($urandom);
		w.x = 8'($urandom);
		w.attr = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 56) begin
			w.cmd = CMD_OBJECT;
			if ($urandom_range(99) < 65)
				w.group[4:0] = block_pool[$urandom_range(3)];
			if ({w.neg_y, w.group, w.x, w.attr} == 32'd0)
				w.attr = 8'h01;
		end else if (pick < 70) begin
			w.cmd = CMD_STORE_WR;
			// Half the store writes land in the busy blocks and change what they draw.
			if ($urandom_range(1))
				w.addr = {1'($urandom), block_pool[$urandom_range(3)], 7'($urandom)};
		end else if (pick < 82) begin
			w.cmd = CMD_SHAPE_WR;
			if ($urandom_range(99) < 80) begin
				w.addr = 13'($urandom_range(SHAPE_BYTES - 1));
				w.data = shape_byte();
			end else begin
				w.addr = 13'($urandom_range(8191, SHAPE_BYTES));
			end
		end else if (pick < 92) begin
			w.cmd = CMD_FRAME;
		end else begin
			w.cmd = CMD_OBJECT;
			w.neg_y = '0;
			w.group = '0;
			w.x = '0;
			w.attr = '0;
		end
	endtask

	// Stops offering words and waits until every tile has come back, then lets the
	// block finish any entry that draws nothing.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_tiles.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_cfg(input cfg_idx_t idx, input bit val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == CFG_SCREEN_FLIP)
			gen_flip = val;
		else
			gen_video = val;
	endtask

	initial begin : stimulus
		item_t w;
		int    i;
		int    mode;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_STORE_WR;
		wr_addr = '0;
		wr_byte = '0;
		obj_neg_y = '0;
		obj_group = '0;
		obj_x = '0;
		obj_attr = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Register changes that a row asks for are made only once the
		// block has gone idle.
		for (i = 0; i < $size(steps); i++) begin
			if (steps[i].flip != gen_flip || steps[i].video != gen_video) begin
				drain_block();
				if (steps[i].flip != gen_flip)
					set_cfg(CFG_SCREEN_FLIP, steps[i].flip);
				if (steps[i].video != gen_video)
					set_cfg(CFG_VIDEO_ON, steps[i].video);
			end
			w.cmd = steps[i].op;
			w.addr = 13'(steps[i].addr);
			w.data = 8'(steps[i].data);
			w.neg_y = 8'(steps[i].neg_y);
			w.group = 8'(steps[i].grp);
			w.x = 8'(steps[i].x);
			w.attr = 8'(steps[i].attr);
			if (w.cmd == CMD_OBJECT)
				prime_reads(w, steps[i].line_fill);
			send_word(w);
			if (steps[i].want >= 0 && last_tile_count != steps[i].want)
				note_fault($sformatf("directed word %0d: %0d tiles expected, %0d predicted",
					i, steps[i].want, last_tile_count));
		end

		// Random part in three idling modes: sender idles more lightly first, then
		// the receiver does, then neither side idles at all.
		for (mode = 0; mode < 3; mode++) begin
			drain_block();
			case (mode)
				0: begin
					snd_idle = 33;
					rcv_idle = 51;
					set_cfg(CFG_SCREEN_FLIP, 1'b0);
				end
				1: begin
					snd_idle = 51;
					rcv_idle = 33;
					set_cfg(CFG_SCREEN_FLIP, 1'b1);
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
					set_cfg(CFG_SCREEN_FLIP, 1'($urandom_range(1)));
				end
			endcase
			for (i = 0; i < WORDS_PER_MODE; i++) begin
				// Once, the sender waits until every tile so far has come back.
				if (mode == 0 && i == WORDS_PER_MODE / 2)
					drain_block();
				// Once, the receiver holds off for a long stretch while words keep
				// coming, so the block fills up and stalls its input.
				if (mode == 2 && i == 8)
					hold_left = LONG_HOLD;
				random_word(w);
				if (w.cmd == CMD_OBJECT)
					prime_reads(w, -1);
				send_word(w);
			end
		end

		in_valid <= 1'b0;
		while (pending_tiles.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("sprite_column_tile_generator regression: pass");
		else
			$display("sprite_column_tile_generator regression: fail");
		$finish;
	end

endmodule
